// ===== hdl/acd_pkg.sv =====
// Shared types, byte codes, command codes and colour maps for the ANSI
// console decoder. No dependencies; imported by the decoder top level.
`default_nettype none

package acd_pkg;

    // Default parameter values for the top level
    localparam int MAX_OPERANDS_DEF = 10;
    localparam int OPERAND_BITS_DEF = 16;

    // Width of the numeric result fields
    localparam int FIELD_W = 16;

    typedef logic [7:0]         byte_t;
    typedef logic [3:0]         action_t;
    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [1:0]         erase_t;
    typedef logic [6:0]         attr_t;
    typedef logic [1:0]         err_t;
    typedef logic [2:0]         color_t;

    // Command codes
    localparam action_t ACT_CHAR   = 4'd0;
    localparam action_t ACT_BKERA  = 4'd1;
    localparam action_t ACT_FWD    = 4'd2;
    localparam action_t ACT_CURSOR = 4'd3;
    localparam action_t ACT_CLEAR  = 4'd4;
    localparam action_t ACT_ERASE  = 4'd5;
    localparam action_t ACT_ATTR   = 4'd6;
    localparam action_t ACT_NL     = 4'd7;
    localparam action_t ACT_ERROR  = 4'd8;

    // Error codes
    localparam err_t ERR_NO_BRACKET = 2'd0;
    localparam err_t ERR_BAD_FINAL  = 2'd1;
    localparam err_t ERR_TOO_MANY   = 2'd2;
    localparam err_t ERR_CUT_OFF    = 2'd3;

    // Erase-line modes
    localparam erase_t ERASE_TO_END   = 2'd0;
    localparam erase_t ERASE_TO_CUR   = 2'd1;
    localparam erase_t ERASE_WHOLE    = 2'd2;

    // Parser phases
    localparam logic [1:0] PH_GROUND = 2'd0;
    localparam logic [1:0] PH_ESC    = 2'd1;
    localparam logic [1:0] PH_CSI    = 2'd2;

    // Byte codes
    localparam byte_t CH_BEL   = 8'h07;
    localparam byte_t CH_BS    = 8'h08;
    localparam byte_t CH_ESC   = 8'h1b;
    localparam byte_t CH_LBRK  = 8'h5b; // '['
    localparam byte_t CH_SEMI  = 8'h3b; // ';'
    localparam byte_t CH_QMARK = 8'h3f; // '?'
    localparam byte_t CH_ZERO  = 8'h30; // '0'
    localparam byte_t CH_NINE  = 8'h39; // '9'
    localparam byte_t FIN_J    = 8'h4a;
    localparam byte_t FIN_C    = 8'h43;
    localparam byte_t FIN_H    = 8'h48;
    localparam byte_t FIN_K    = 8'h4b;
    localparam byte_t FIN_M    = 8'h6d; // 'm'
    localparam byte_t FIN_L    = 8'h4c;

    // SGR operand values
    localparam int SGR_RESET   = 0;
    localparam int SGR_INVERSE = 7;
    localparam int SGR_FG_BASE = 30;
    localparam int SGR_BG_BASE = 40;
    localparam int SGR_SPAN    = 7;

    localparam color_t FG_RESET = 3'd7;
    localparam color_t BG_RESET = 3'd0;

    // One result beat, all fields; unused fields stay zero
    typedef struct packed {
        action_t action;
        byte_t   char_out;
        field_t  move_count;
        field_t  target_col;
        field_t  target_row;
        erase_t  erase_mode;
        attr_t   attribute;
        err_t    error_code;
    } result_t;

    // ANSI colour index to console foreground code
    function automatic attr_t fg_code(input color_t idx);
        attr_t c;
        case (idx)
            3'd0:    c = 7'h00;
            3'd1:    c = 7'h04;
            3'd2:    c = 7'h02;
            3'd3:    c = 7'h0e;
            3'd4:    c = 7'h01;
            3'd5:    c = 7'h05;
            3'd6:    c = 7'h03;
            default: c = 7'h0f;
        endcase
        return c;
    endfunction

    // ANSI colour index to console background code
    function automatic attr_t bg_code(input color_t idx);
        attr_t c;
        case (idx)
            3'd0:    c = 7'h00;
            3'd1:    c = 7'h40;
            3'd2:    c = 7'h20;
            3'd3:    c = 7'h60;
            3'd4:    c = 7'h10;
            3'd5:    c = 7'h50;
            3'd6:    c = 7'h30;
            default: c = 7'h70;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ansi_escape_console_decoder_unit.sv =====
// ANSI CSI escape sequence decoder: bytes in, console command beats out.
// Depends on acd_pkg (types, byte and command codes, colour maps).
`default_nettype none
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  s_      | in        | s_valid / s_ready | s_byte_in, s_last_in_buffer
//  m_      | out       | m_valid / m_ready | m_action, m_char_out, m_move_count,
//          |           |                   | m_target_col, m_target_row, m_erase_mode,
//          |           |                   | m_attribute, m_error_code
//
// Throughput: one byte per cycle while m_ready is high; a byte passes the
//   input register, then the result register, before its result is
//   presented.
// The parser state (phase, two stored operands, operand count, colours) is
//   updated in one pass of small logic between the two registers.
// Reset (aresetn low, synchronous) empties both registers and returns the
//   parser to ground with white on black.
// Stalls: while m_ready is low and a result waits, the input register still
//   holds one byte; s_ready drops only when both registers are full.

module ansi_escape_console_decoder_unit #(
    parameter int MAX_OPERANDS = acd_pkg::MAX_OPERANDS_DEF,
    parameter int OPERAND_BITS = acd_pkg::OPERAND_BITS_DEF
) (
    input  wire                    aclk,
    input  wire                    aresetn,

    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire acd_pkg::byte_t    s_byte_in,
    input  wire                    s_last_in_buffer,

    output logic                   m_valid,
    input  wire                    m_ready,
    output acd_pkg::action_t       m_action,
    output acd_pkg::byte_t         m_char_out,
    output acd_pkg::field_t        m_move_count,
    output acd_pkg::field_t        m_target_col,
    output acd_pkg::field_t        m_target_row,
    output acd_pkg::erase_t        m_erase_mode,
    output acd_pkg::attr_t         m_attribute,
    output acd_pkg::err_t          m_error_code
);

    import acd_pkg::*;

    localparam int CNT_W  = $clog2(MAX_OPERANDS + 1);
    localparam int WIDE_W = (OPERAND_BITS > FIELD_W) ? OPERAND_BITS : FIELD_W;
    localparam int PROD_W = OPERAND_BITS + 4;

    typedef logic [OPERAND_BITS-1:0] operand_t;

    // Input register
    logic     in_valid_reg;
    byte_t    in_byte_reg;
    logic     in_last_reg;

    // Result register
    logic     out_valid_reg;
    logic     out_valid_next;
    result_t  result_reg;

    // Parser state
    logic [1:0]       phase_reg,  phase_next;
    operand_t         op0_reg,    op0_next;
    operand_t         op1_reg,    op1_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    color_t           fg_reg,     fg_next;
    color_t           bg_reg,     bg_next;

    // Decode outputs
    result_t  res_c;
    logic     emit_c;

    // Handshake control
    logic     out_free;
    logic     advance;

    // Digit accumulation helpers
    logic [3:0]        digit;
    operand_t          acc_sel;
    logic [PROD_W-1:0] acc_prod;
    operand_t          acc_sat;
    logic [7:0]        op0_low;
    logic [7:0]        sgr_off_fg;
    logic [7:0]        sgr_off_bg;
    logic              op0_small;

    // Operand to 16-bit result field: zero-extend or truncate
    function automatic field_t to_field(input operand_t v);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        return w[FIELD_W-1:0];
    endfunction

    // Advance the input register whenever the result register can take a
    // new beat; bytes that make no result pass through the same way.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Payload needs no reset; capture on every beat
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_in;
            in_last_reg <= s_last_in_buffer;
        end
    end

    // Multiply-accumulate the current operand by ten, saturating
    assign digit    = 4'(in_byte_reg - CH_ZERO);
    assign acc_sel  = (count_reg == CNT_W'(1)) ? op0_reg : op1_reg;
    assign acc_prod = (PROD_W'(acc_sel) << 3) + (PROD_W'(acc_sel) << 1) + PROD_W'(digit);
    assign acc_sat  = (acc_prod[PROD_W-1:OPERAND_BITS] != 4'd0) ? {OPERAND_BITS{1'b1}}
                                                                : acc_prod[OPERAND_BITS-1:0];

    // SGR operand checks; operands are at least 8 bits wide
    assign op0_low    = op0_reg[7:0];
    assign op0_small  = (op0_reg >> 8) == '0;
    assign sgr_off_fg = op0_low - 8'(SGR_FG_BASE);
    assign sgr_off_bg = op0_low - 8'(SGR_BG_BASE);

    always_comb begin
        phase_next = phase_reg;
        op0_next   = op0_reg;
        op1_next   = op1_reg;
        count_next = count_reg;
        fg_next    = fg_reg;
        bg_next    = bg_reg;
        res_c      = '0;
        emit_c     = 1'b0;

        case (phase_reg)
            PH_ESC: begin
                if (in_byte_reg != CH_LBRK) begin
                    // Drop both bytes, report and fall back to ground
                    phase_next       = PH_GROUND;
                    emit_c           = 1'b1;
                    res_c.action     = ACT_ERROR;
                    res_c.error_code = ERR_NO_BRACKET;
                end else begin
                    phase_next = PH_CSI;
                    op0_next   = '0;
                    op1_next   = '0;
                    count_next = CNT_W'(1);
                    if (in_last_reg) begin
                        phase_next       = PH_GROUND;
                        emit_c           = 1'b1;
                        res_c.action     = ACT_ERROR;
                        res_c.error_code = ERR_CUT_OFF;
                    end
                end
            end

            PH_CSI: begin
                if (in_byte_reg >= CH_ZERO && in_byte_reg <= CH_NINE) begin
                    // Only the first two operands are stored
                    if (count_reg == CNT_W'(1)) begin
                        op0_next = acc_sat;
                    end else if (count_reg == CNT_W'(2)) begin
                        op1_next = acc_sat;
                    end
                    if (in_last_reg) begin
                        phase_next       = PH_GROUND;
                        emit_c           = 1'b1;
                        res_c.action     = ACT_ERROR;
                        res_c.error_code = ERR_CUT_OFF;
                    end
                end else if (in_byte_reg == CH_SEMI || in_byte_reg == CH_QMARK) begin
                    if (count_reg >= CNT_W'(MAX_OPERANDS)) begin
                        phase_next       = PH_GROUND;
                        emit_c           = 1'b1;
                        res_c.action     = ACT_ERROR;
                        res_c.error_code = ERR_TOO_MANY;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                        if (in_last_reg) begin
                            phase_next       = PH_GROUND;
                            emit_c           = 1'b1;
                            res_c.action     = ACT_ERROR;
                            res_c.error_code = ERR_CUT_OFF;
                        end
                    end
                end else begin
                    // Final byte closes the sequence
                    phase_next = PH_GROUND;
                    emit_c     = 1'b1;
                    case (in_byte_reg)
                        FIN_J: begin
                            res_c.action = ACT_CLEAR;
                        end
                        FIN_C: begin
                            res_c.action     = ACT_FWD;
                            res_c.move_count = to_field((op0_reg == '0) ?
                                                        OPERAND_BITS'(1) : op0_reg);
                        end
                        FIN_H: begin
                            res_c.action     = ACT_CURSOR;
                            res_c.target_col = to_field((op1_reg == '0) ?
                                                        '0 : op1_reg - OPERAND_BITS'(1));
                            res_c.target_row = to_field((op0_reg == '0) ?
                                                        '0 : op0_reg - OPERAND_BITS'(1));
                        end
                        FIN_K: begin
                            res_c.action = ACT_ERASE;
                            if (op0_reg == OPERAND_BITS'(2)) begin
                                res_c.erase_mode = ERASE_WHOLE;
                            end else if (op0_reg == OPERAND_BITS'(1)) begin
                                res_c.erase_mode = ERASE_TO_CUR;
                            end else begin
                                res_c.erase_mode = ERASE_TO_END;
                            end
                        end
                        FIN_M: begin
                            res_c.action = ACT_ATTR;
                            if (op0_reg == OPERAND_BITS'(SGR_RESET)) begin
                                fg_next = FG_RESET;
                                bg_next = BG_RESET;
                            end else if (op0_reg == OPERAND_BITS'(SGR_INVERSE)) begin
                                fg_next = bg_reg;
                                bg_next = fg_reg;
                            end else if (op0_small && sgr_off_fg <= 8'(SGR_SPAN)) begin
                                fg_next = sgr_off_fg[2:0];
                            end else if (op0_small && sgr_off_bg <= 8'(SGR_SPAN)) begin
                                bg_next = sgr_off_bg[2:0];
                            end else begin
                                // Unsupported mode: no beat, colours kept
                                emit_c       = 1'b0;
                                res_c.action = ACT_CHAR;
                            end
                            res_c.attribute = emit_c ? (fg_code(fg_next) | bg_code(bg_next))
                                                     : '0;
                        end
                        FIN_L: begin
                            res_c.action = ACT_NL;
                        end
                        default: begin
                            res_c.action     = ACT_ERROR;
                            res_c.error_code = ERR_BAD_FINAL;
                        end
                    endcase
                end
            end

            default: begin
                // Ground
                phase_next = PH_GROUND;
                if (in_byte_reg == CH_BEL) begin
                    emit_c = 1'b0;
                end else if (in_byte_reg == CH_BS) begin
                    emit_c       = 1'b1;
                    res_c.action = ACT_BKERA;
                end else if (in_byte_reg == CH_ESC) begin
                    phase_next = PH_ESC;
                    if (in_last_reg) begin
                        phase_next       = PH_GROUND;
                        emit_c           = 1'b1;
                        res_c.action     = ACT_ERROR;
                        res_c.error_code = ERR_CUT_OFF;
                    end
                end else begin
                    emit_c         = 1'b1;
                    res_c.action   = ACT_CHAR;
                    res_c.char_out = in_byte_reg;
                end
            end
        endcase
    end

    // Parser state advances once per byte leaving the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_GROUND;
            op0_reg   <= '0;
            op1_reg   <= '0;
            count_reg <= '0;
            fg_reg    <= FG_RESET;
            bg_reg    <= BG_RESET;
        end else if (advance) begin
            phase_reg <= phase_next;
            op0_reg   <= op0_next;
            op1_reg   <= op1_next;
            count_reg <= count_next;
            fg_reg    <= fg_next;
            bg_reg    <= bg_next;
        end
    end

    // Result register: load on a producing byte, drop after the beat
    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if (advance && emit_c) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit_c) begin
            result_reg <= res_c;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_action     = result_reg.action;
    assign m_char_out   = result_reg.char_out;
    assign m_move_count = result_reg.move_count;
    assign m_target_col = result_reg.target_col;
    assign m_target_row = result_reg.target_row;
    assign m_erase_mode = result_reg.erase_mode;
    assign m_attribute  = result_reg.attribute;
    assign m_error_code = result_reg.error_code;

    // Any error beat leaves the parser at ground
    a_error_to_ground: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit_c && res_c.action == ACT_ERROR) |=> (phase_reg == PH_GROUND))
        else $error("parser not at ground after an error beat");

    // Operand count never runs past its limit
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_OPERANDS))
        else $error("operand count above limit");

    // A producing byte always shows up as a result beat next cycle
    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit_c) |=> m_valid)
        else $error("result beat lost");

    // Input side stalls only with both registers full and the output blocked
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without cause");

endmodule

`default_nettype wire
